// ===== sv/tss_pkg.sv =====
package tss_pkg;

  // Stages in front of the divider: orient edge, multiply, sum and clamp
  localparam int unsigned PRE_DIV_STAGES = 3;

  // Edges a-b, b-c, c-a
  localparam int unsigned NUM_EDGES = 3;

endpackage

// ===== sv/tss_edge.sv =====
module tss_edge
  import tss_pkg::*;
#(
  parameter int unsigned COORD_INT_BITS  = 12,
  parameter int unsigned COORD_FRAC_BITS = 4
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] x0_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] y0_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] x1_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] y1_i,
  input  logic [COORD_INT_BITS-1:0]                 line_i,
  output logic                                     hit_o,
  output logic [COORD_INT_BITS-1:0]                 xpix_o
);

  localparam int unsigned W   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int unsigned PW  = 2 * W + 2;  // signed product and sum width
  localparam int unsigned RW  = 2 * W + 1;  // clamped numerator width
  localparam int unsigned HL  = PRE_DIV_STAGES + COORD_INT_BITS;

  // ---------------- stage 1: orient edge, test line, differences
  logic               swap;
  logic [W-1:0]       ux, uy, vx, vy;
  logic [W-1:0]       line_fx;
  logic               hit_d;
  logic [W-1:0]       ux_q, den_q, dy_q;
  logic signed [W:0]  dx_q;

  assign swap    = (y0_i > y1_i);
  assign ux      = swap ? x1_i : x0_i;
  assign uy      = swap ? y1_i : y0_i;
  assign vx      = swap ? x0_i : x1_i;
  assign vy      = swap ? y0_i : y1_i;
  assign line_fx = W'(line_i) << COORD_FRAC_BITS;
  assign hit_d   = (COORD_INT_BITS'(uy >> COORD_FRAC_BITS) < line_i) &&
                   (line_i <= COORD_INT_BITS'(vy >> COORD_FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q  <= ux;
      den_q <= vy - uy;
      dy_q  <= line_fx - uy;
      dx_q  <= $signed({1'b0, vx}) - $signed({1'b0, ux});
    end
  end

  // ---------------- stage 2: base and slope products
  logic [2*W-1:0]         base_q;
  logic signed [PW-1:0]   slope_q;
  logic [W-1:0]           den2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q  <= (2*W)'(ux_q) * (2*W)'(den_q);
      slope_q <= PW'($signed({1'b0, dy_q})) * PW'(dx_q);
      den2_q  <= den_q;
    end
  end

  // ---------------- stage 3: sum, clamp at zero
  logic signed [PW-1:0] total;
  logic [RW-1:0]        rem_q [COORD_INT_BITS+1];
  logic [COORD_INT_BITS-1:0] quo_q [COORD_INT_BITS+1];
  logic [W-1:0]         dvs_q [COORD_INT_BITS+1];

  assign total = $signed({2'b00, base_q}) + slope_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= total[PW-1] ? '0 : total[RW-1:0];
      quo_q[0] <= '0;
      dvs_q[0] <= den2_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < COORD_INT_BITS; j++) begin : g_div
    localparam int unsigned SH = COORD_FRAC_BITS + COORD_INT_BITS - 1 - j;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(dvs_q[j]) << SH;
    assign ge    = (rem_q[j] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? (rem_q[j] - trial) : rem_q[j];
        quo_q[j+1] <= {quo_q[j][COORD_INT_BITS-2:0], ge};
        dvs_q[j+1] <= dvs_q[j];
      end
    end
  end

  // ---------------- edge hit flag travels beside the data
  logic hit_q [HL];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q[0] <= hit_d;
      for (int k = 1; k < HL; k++) begin
        hit_q[k] <= hit_q[k-1];
      end
    end
  end

  assign hit_o  = hit_q[HL-1];
  assign xpix_o = quo_q[COORD_INT_BITS];

endmodule

// ===== sv/triangle_scanline_span.sv =====
// Pipeline from input transfer to result:
//   orient/test, multiply, sum, one divider stage per pixel bit, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Reset (rst_ni low, asynchronous) clears the stage valid bits and the output valid.
module triangle_scanline_span
  import tss_pkg::*;
#(
  parameter int unsigned COORD_INT_BITS  = 12,
  parameter int unsigned COORD_FRAC_BITS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, line_y,
  // zero pad
  input  logic [((6*(COORD_INT_BITS+COORD_FRAC_BITS)+COORD_INT_BITS+7)/8)*8-1:0]
               s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // span_start, span_end, zero pad
  output logic [((2*COORD_INT_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // span_valid
  output logic m_axis_tuser_o
);

  localparam int unsigned W   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int unsigned LAT = PRE_DIV_STAGES + COORD_INT_BITS;
  localparam int unsigned ODW = ((2 * COORD_INT_BITS + 7) / 8) * 8;

  logic en;
  logic [W-1:0]              vx [NUM_EDGES];
  logic [W-1:0]              vy [NUM_EDGES];
  logic [COORD_INT_BITS-1:0] line_y;
  logic                      hit  [NUM_EDGES];
  logic [COORD_INT_BITS-1:0] xpix [NUM_EDGES];

  // Advance everything unless a finished result is still waiting
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar v = 0; v < NUM_EDGES; v++) begin : g_unpack
    assign vx[v] = s_axis_tdata_i[2*v*W +: W];
    assign vy[v] = s_axis_tdata_i[(2*v+1)*W +: W];
  end
  assign line_y = s_axis_tdata_i[2*NUM_EDGES*W +: COORD_INT_BITS];

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    tss_edge #(
      .COORD_INT_BITS (COORD_INT_BITS),
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_edge (
      .clk_i  (clk_i),
      .en_i   (en),
      .x0_i   (vx[e]),
      .y0_i   (vy[e]),
      .x1_i   (vx[(e+1)%NUM_EDGES]),
      .y1_i   (vy[(e+1)%NUM_EDGES]),
      .line_i (line_y),
      .hit_o  (hit[e]),
      .xpix_o (xpix[e])
    );
  end

  // Stage valid bits
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // Pick the two crossings and order them
  logic                      two;
  logic [COORD_INT_BITS-1:0] xa, xb;
  logic                      span_valid_d, span_valid_q;
  logic [COORD_INT_BITS-1:0] span_start_d, span_end_d, span_start_q, span_end_q;
  logic                      out_vld_q;

  assign two = (hit[0] && hit[1] && !hit[2]) || (hit[0] && !hit[1] && hit[2]) ||
               (!hit[0] && hit[1] && hit[2]);

  always_comb begin
    if (!hit[0]) begin
      xa = xpix[1];
      xb = xpix[2];
    end else if (!hit[1]) begin
      xa = xpix[0];
      xb = xpix[2];
    end else begin
      xa = xpix[0];
      xb = xpix[1];
    end
    span_valid_d = two;
    span_start_d = '0;
    span_end_d   = '0;
    if (two) begin
      span_start_d = (xa < xb) ? xa : xb;
      span_end_d   = (xa < xb) ? xb : xa;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      span_valid_q <= span_valid_d;
      span_start_q <= span_start_d;
      span_end_q   <= span_end_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = span_valid_q;
  assign m_axis_tdata_o  = ODW'({span_end_q, span_start_q});

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import tss_pkg::*;
();

  localparam int unsigned INT_BITS  = 12;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned COORD_W   = INT_BITS + FRAC_BITS;
  localparam int unsigned IN_W      = ((6 * COORD_W + INT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W     = ((2 * INT_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_TRIANGLES = 900;
  localparam int unsigned DRAIN_CYCLES     = 3 * (INT_BITS + 4 + PRE_DIV_STAGES);
  localparam int unsigned CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic [INT_BITS-1:0] line;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  by;
    logic [COORD_W-1:0]  bx;
    logic [COORD_W-1:0]  ay;
    logic [COORD_W-1:0]  ax;
  } triangle_t;

  typedef struct {
    bit                valid;
    bit [INT_BITS-1:0] lo;
    bit [INT_BITS-1:0] hi;
  } span_t;

  class span_scoreboard;
    span_t pending_spans[$];
    int    errors;

    // Floor of the crossing of one edge with the scanline; 0 when it does not count.
    function bit edge_crossing(longint x0, longint y0, longint x1, longint y1,
                               longint line, output bit [INT_BITS-1:0] px);
      longint ux, uy, vx, vy, den, num, total;
      if (y0 <= y1) begin
        ux = x0; uy = y0; vx = x1; vy = y1;
      end else begin
        ux = x1; uy = y1; vx = x0; vy = y0;
      end
      px = '0;
      if (!((uy >> FRAC_BITS) < line && line <= (vy >> FRAC_BITS))) return 1'b0;
      den   = vy - uy;
      num   = ((line << FRAC_BITS) - uy) * (vx - ux);
      total = ux * den + num;
      if (total < 0) total = 0;
      px = INT_BITS'(total / (den << FRAC_BITS));
      return 1'b1;
    endfunction

    function void note_triangle(triangle_t t);
      longint            xs[3], ys[3];
      bit [INT_BITS-1:0] crossings[2];
      bit [INT_BITS-1:0] px;
      int                hits;
      span_t             s;
      xs[0] = t.ax; ys[0] = t.ay;
      xs[1] = t.bx; ys[1] = t.by;
      xs[2] = t.cx; ys[2] = t.cy;
      hits = 0;
      for (int i = 0; i < 3; i++) begin
        if (edge_crossing(xs[i], ys[i], xs[(i + 1) % 3], ys[(i + 1) % 3], t.line, px)) begin
          if (hits < 2) crossings[hits] = px;
          hits++;
        end
      end
      s = '{valid: 1'b0, lo: '0, hi: '0};
      if (hits == 2) begin
        s.valid = 1'b1;
        s.lo    = (crossings[0] < crossings[1]) ? crossings[0] : crossings[1];
        s.hi    = (crossings[0] < crossings[1]) ? crossings[1] : crossings[0];
      end
      pending_spans.insert(pending_spans.size(), s);
    endfunction

    function void check_span(bit valid, bit [INT_BITS-1:0] lo, bit [INT_BITS-1:0] hi);
      span_t s;
      if (pending_spans.size() == 0) begin
        $error("span result with nothing pending: span_valid %0d start %0d end %0d",
               valid, lo, hi);
        errors++;
        return;
      end
      s = pending_spans.pop_front();
      if (valid !== s.valid) begin
        $error("span_valid mismatch: expected %0d, actual %0d", s.valid, valid);
        errors++;
      end
      if (lo !== s.lo) begin
        $error("span_start mismatch: expected %0d, actual %0d", s.lo, lo);
        errors++;
      end
      if (hi !== s.hi) begin
        $error("span_end mismatch: expected %0d, actual %0d", s.hi, hi);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  span_scoreboard sb;
  int             burst_left;
  int             results_seen;
  int             cycle_count;

  triangle_scanline_span #(
    .COORD_INT_BITS (INT_BITS),
    .COORD_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic triangle_t make_triangle(int ax, int ay, int bx, int by,
                                              int cx, int cy, int line);
    triangle_t t;
    t.ax = COORD_W'(ax); t.ay = COORD_W'(ay);
    t.bx = COORD_W'(bx); t.by = COORD_W'(by);
    t.cx = COORD_W'(cx); t.cy = COORD_W'(cy);
    t.line = INT_BITS'(line);
    return t;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > (1 << COORD_W) - 1) return (1 << COORD_W) - 1;
    return v;
  endfunction

  function automatic int jitter(int center, int spread);
    return clamp_coord(center + $urandom_range(0, 2 * spread) - spread);
  endfunction

  // Triangle shaped to straddle its scanline most of the time, with exact hits on
  // pixel rows, shared floors and a few wild vertices mixed in.
  function automatic triangle_t random_triangle();
    int line, base, spread, xspread, xc, rot;
    int xs[3], ys[3];
    line    = $urandom_range(0, (1 << INT_BITS) - 1);
    base    = line << FRAC_BITS;
    spread  = 16 << $urandom_range(0, 11);
    xspread = 16 << $urandom_range(0, 11);
    xc      = $urandom_range(0, (1 << COORD_W) - 1);
    ys[0]   = clamp_coord(base - 1 - $urandom_range(0, spread));
    ys[1]   = clamp_coord(base + 16 + $urandom_range(0, spread));
    ys[2]   = jitter(base, spread);
    for (int i = 0; i < 3; i++) begin
      xs[i] = jitter(xc, xspread);
      case ($urandom_range(0, 11))
        0: ys[i] = base;
        1: ys[i] = clamp_coord(base + 15);
        2: ys[i] = clamp_coord(base - 16 + $urandom_range(0, 15));
        3: ys[i] = ys[(i + 1) % 3];
        4: xs[i] = $urandom_range(0, (1 << COORD_W) - 1);
        default: ;
      endcase
    end
    case ($urandom_range(0, 19))
      0, 1: return make_triangle($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
      // move the scanline just outside the vertical extent
      2: line = (ys[1] >> FRAC_BITS) + 1;
      3: line = (ys[0] >> FRAC_BITS);
      default: ;
    endcase
    rot = $urandom_range(0, 5);
    if (rot >= 3) begin
      int tx, ty;
      tx = xs[0]; ty = ys[0]; xs[0] = xs[1]; ys[0] = ys[1]; xs[1] = tx; ys[1] = ty;
    end
    rot = rot % 3;
    return make_triangle(xs[rot], ys[rot], xs[(rot + 1) % 3], ys[(rot + 1) % 3],
                         xs[(rot + 2) % 3], ys[(rot + 2) % 3], line);
  endfunction

  // Offer one triangle, with bursts separated by random gaps; note it on transfer.
  task automatic send_triangle(triangle_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(t);
    do @(posedge clk_i); while (!s_tready);
    sb.note_triangle(t);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no span at the bottom and top corners of the coordinate space
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_triangle(65535, 65535, 65535, 65535, 65535, 65535, 4095));
    // full-height triangle: top row, bottom row, row above the lowest vertex
    send_triangle(make_triangle(0, 0, 65535, 65535, 0, 65535, 4095));
    send_triangle(make_triangle(0, 0, 65535, 65535, 0, 65535, 0));
    send_triangle(make_triangle(0, 0, 65535, 65535, 0, 65535, 1));
    send_triangle(make_triangle(65535, 0, 0, 65535, 65535, 65535, 2048));
    // horizontal edge: on its own row, and one row further up
    send_triangle(make_triangle(16, 160, 800, 160, 400, 800, 10));
    send_triangle(make_triangle(16, 160, 800, 160, 400, 800, 11));
    send_triangle(make_triangle(400, 160, 16, 800, 800, 800, 50));
    send_triangle(make_triangle(400, 160, 16, 800, 800, 800, 51));
    // vertex exactly on the scanline, and the same triangle reversed
    send_triangle(make_triangle(100, 320, 900, 640, 50, 960, 20));
    send_triangle(make_triangle(50, 960, 900, 640, 100, 320, 20));
    send_triangle(make_triangle(100, 320, 900, 640, 50, 960, 40));
    // all vertices within one pixel row
    send_triangle(make_triangle(10, 480, 500, 487, 900, 495, 30));
    // fractions all ones, steep and shallow edges
    send_triangle(make_triangle(15, 15, 65535, 31, 32767, 65535, 1));
    send_triangle(make_triangle(65520, 15, 65535, 65535, 0, 65519, 4094));
    send_triangle(make_triangle(32768, 1, 32769, 65535, 1, 65534, 3000));
    send_triangle(make_triangle(4095, 4096, 61440, 4111, 30000, 8191, 257));
    // line above the top vertex
    send_triangle(make_triangle(100, 100, 200, 200, 300, 300, 19));
    send_triangle(make_triangle(43690, 21845, 21845, 43690, 52428, 13107, 2730));

    repeat (RANDOM_TRIANGLES) send_triangle(random_triangle());
    s_tvalid <= 1'b0;

    while (sb.pending_spans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: check each transfer, then pick the next ready value.
  initial begin
    int mode, mode_left, hold_left;
    bit held;
    mode = 0; mode_left = 0; hold_left = 0; held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        sb.check_span(m_tuser, m_tdata[INT_BITS-1:0], m_tdata[2*INT_BITS-1:INT_BITS]);
        results_seen++;
      end
      // one long hold-off so the pipeline fills and backs up into the input
      if (!held && results_seen >= 300) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) < 7);
          2: m_tready <= ($urandom_range(0, 9) < 3);
          default: m_tready <= (mode_left % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
